/* hw/rtl/cllre_pkg.sv */
// Shared types, widths and action codes for the circular linked ring editor.
`timescale 1ns / 1ps
`default_nettype none
package cllre_pkg;

  localparam int ID_W          = 10;
  localparam int ACT_W         = 3;
  localparam int NODE_COUNT    = 1024;
  localparam int IN_FIELDS_W   = ACT_W + 2 * ID_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((ID_W + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_LOAD       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_AFTER  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INS_BEFORE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_AFTER  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REM_BEFORE = 3'd4;

  typedef logic [ID_W-1:0] node_id_t;

  // Write and read requests from the sequencer to the two link tables.
  typedef struct packed {
    logic     next_we;
    node_id_t next_waddr;
    node_id_t next_wdata;
    logic     prev_we;
    node_id_t prev_waddr;
    node_id_t prev_wdata;
    node_id_t raddr;
  } link_req_t;

endpackage
`default_nettype wire

/* hw/rtl/cllre_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module cllre_ram #(
  parameter int WIDTH = cllre_pkg::ID_W,
  parameter int DEPTH = cllre_pkg::NODE_COUNT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/cllre_seq.sv */
// Sequencer that walks each load, insert or remove request through its link reads and link writes.
`timescale 1ns / 1ps
`default_nettype none
module cllre_seq #(
  parameter int NODE_COUNT = cllre_pkg::NODE_COUNT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [cllre_pkg::ACT_W-1:0] in_action,
  input  wire cllre_pkg::node_id_t      in_node_a,
  input  wire cllre_pkg::node_id_t      in_node_b,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output cllre_pkg::node_id_t           out_neighbour,
  output cllre_pkg::link_req_t          req,
  input  wire cllre_pkg::node_id_t      next_rdata,
  input  wire cllre_pkg::node_id_t      prev_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ1 = 3'd1;
  localparam logic [2:0] S_READ2 = 3'd2;
  localparam logic [2:0] S_WR1   = 3'd3;
  localparam logic [2:0] S_WR2   = 3'd4;

  logic [2:0]                    state, state_next;
  logic [cllre_pkg::ACT_W-1:0]   act;
  cllre_pkg::node_id_t           node_a, node_b, link_c, link_d;
  cllre_pkg::node_id_t           head, tail;
  logic                          started;
  logic                          rd_ok;
  cllre_pkg::node_id_t           rd_val;
  cllre_pkg::link_req_t          raw;
  logic                          finish, stall, accept;

  function automatic logic id_ok(input cllre_pkg::node_id_t id);
    return 32'(id) < NODE_COUNT;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign stall    = out_valid && !out_ready;

  // Registered link read, forced to zero for identifiers beyond the table.
  always_comb begin
    if (!rd_ok) begin
      rd_val = '0;
    end else if (act == cllre_pkg::ACT_REM_AFTER || act == cllre_pkg::ACT_INS_AFTER) begin
      rd_val = next_rdata;
    end else begin
      rd_val = prev_rdata;
    end
  end

  always_comb begin
    raw        = '0;
    finish     = 1'b0;
    state_next = state;
    raw.raddr  = (state == S_IDLE) ? in_node_a : rd_val;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_action == cllre_pkg::ACT_LOAD) begin
            state_next = S_WR1;
          end else if (in_action <= cllre_pkg::ACT_REM_BEFORE) begin
            state_next = S_READ1;
          end
        end
      end
      S_READ1: begin
        if (act == cllre_pkg::ACT_REM_AFTER || act == cllre_pkg::ACT_REM_BEFORE) begin
          state_next = S_READ2;
        end else begin
          state_next = S_WR1;
        end
      end
      S_READ2: begin
        state_next = S_WR1;
      end
      S_WR1: begin
        case (act)
          cllre_pkg::ACT_LOAD: begin
            if (!started) begin
              raw.next_we = 1'b1; raw.next_waddr = node_a; raw.next_wdata = node_a;
              raw.prev_we = 1'b1; raw.prev_waddr = node_a; raw.prev_wdata = node_a;
              state_next  = S_IDLE;
            end else begin
              raw.next_we = 1'b1; raw.next_waddr = tail;   raw.next_wdata = node_a;
              raw.prev_we = 1'b1; raw.prev_waddr = node_a; raw.prev_wdata = tail;
              state_next  = S_WR2;
            end
          end
          cllre_pkg::ACT_INS_AFTER: begin
            raw.next_we = 1'b1; raw.next_waddr = node_b; raw.next_wdata = link_c;
            raw.prev_we = 1'b1; raw.prev_waddr = node_b; raw.prev_wdata = node_a;
            state_next  = S_WR2;
          end
          cllre_pkg::ACT_INS_BEFORE: begin
            raw.prev_we = 1'b1; raw.prev_waddr = node_b; raw.prev_wdata = link_c;
            raw.next_we = 1'b1; raw.next_waddr = node_b; raw.next_wdata = node_a;
            state_next  = S_WR2;
          end
          cllre_pkg::ACT_REM_AFTER: begin
            raw.next_we = 1'b1; raw.next_waddr = node_a; raw.next_wdata = link_d;
            raw.prev_we = 1'b1; raw.prev_waddr = link_d; raw.prev_wdata = node_a;
            finish      = 1'b1;
          end
          cllre_pkg::ACT_REM_BEFORE: begin
            raw.prev_we = 1'b1; raw.prev_waddr = node_a; raw.prev_wdata = link_d;
            raw.next_we = 1'b1; raw.next_waddr = link_d; raw.next_wdata = node_a;
            finish      = 1'b1;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_WR2: begin
        case (act)
          cllre_pkg::ACT_LOAD: begin
            raw.next_we = 1'b1; raw.next_waddr = node_a; raw.next_wdata = head;
            raw.prev_we = 1'b1; raw.prev_waddr = head;   raw.prev_wdata = node_a;
            state_next  = S_IDLE;
          end
          cllre_pkg::ACT_INS_AFTER: begin
            raw.next_we = 1'b1; raw.next_waddr = node_a; raw.next_wdata = node_b;
            raw.prev_we = 1'b1; raw.prev_waddr = link_c; raw.prev_wdata = node_b;
            finish      = 1'b1;
          end
          cllre_pkg::ACT_INS_BEFORE: begin
            raw.prev_we = 1'b1; raw.prev_waddr = node_a; raw.prev_wdata = node_b;
            raw.next_we = 1'b1; raw.next_waddr = link_c; raw.next_wdata = node_b;
            finish      = 1'b1;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      state_next = stall ? state : S_IDLE;
    end
  end

  always_comb begin
    req         = raw;
    req.next_we = raw.next_we && id_ok(raw.next_waddr) && !(finish && stall);
    req.prev_we = raw.prev_we && id_ok(raw.prev_waddr) && !(finish && stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      head      <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish && !stall) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_WR1 && act == cllre_pkg::ACT_LOAD && !started) begin
        started <= 1'b1;
        head    <= node_a;
        tail    <= node_a;
      end
      if (state == S_WR2 && act == cllre_pkg::ACT_LOAD) begin
        tail <= node_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= id_ok(raw.raddr);
    if (accept) begin
      act    <= in_action;
      node_a <= in_node_a;
      node_b <= in_node_b;
    end
    if (state == S_READ1) begin
      link_c <= rd_val;
    end
    if (state == S_READ2) begin
      link_d <= rd_val;
    end
    if (finish && !stall) begin
      out_neighbour <= link_c;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/circular_linked_ring_editor_core.sv */
// Top level of the circular linked ring editor: sequencer and two link tables.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   action, node_a, node_b
//   m_*       out        m_tvalid/m_tready   neighbour
//
// A load goes through S_WR1, then S_WR2 after the first; an insert S_READ1, S_WR1,
// S_WR2; a remove S_READ1, S_READ2, S_WR1, set by the dependent reads and the one
// write port of each link table. Reset clears the ring head, tail and start flag;
// link tables are not cleared. A request is accepted only when the sequencer is idle;
// a result waiting in the output register holds the last write step until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module circular_linked_ring_editor_core #(
  parameter int NODE_COUNT = cllre_pkg::NODE_COUNT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [cllre_pkg::IN_TDATA_W-1:0]   s_tdata,  // action, node_a, node_b
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [cllre_pkg::OUT_TDATA_W-1:0]  m_tdata   // neighbour
);

  localparam int ADDR_W = $clog2(NODE_COUNT);

  cllre_pkg::link_req_t req;
  cllre_pkg::node_id_t  next_rdata, prev_rdata, neighbour;
  logic [cllre_pkg::ACT_W-1:0] action;
  cllre_pkg::node_id_t  node_a, node_b;

  assign action = s_tdata[cllre_pkg::ACT_W-1:0];
  assign node_a = s_tdata[cllre_pkg::ACT_W +: cllre_pkg::ID_W];
  assign node_b = s_tdata[cllre_pkg::ACT_W + cllre_pkg::ID_W +: cllre_pkg::ID_W];
  assign m_tdata = cllre_pkg::OUT_TDATA_W'(neighbour);

  cllre_seq #(
    .NODE_COUNT(NODE_COUNT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_action    (action),
    .in_node_a    (node_a),
    .in_node_b    (node_b),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_neighbour(neighbour),
    .req          (req),
    .next_rdata   (next_rdata),
    .prev_rdata   (prev_rdata)
  );

  cllre_ram #(
    .WIDTH(cllre_pkg::ID_W),
    .DEPTH(NODE_COUNT)
  ) u_next_tab (
    .clk  (clk),
    .we   (req.next_we),
    .waddr(ADDR_W'(req.next_waddr)),
    .wdata(req.next_wdata),
    .raddr(ADDR_W'(req.raddr)),
    .rdata(next_rdata)
  );

  cllre_ram #(
    .WIDTH(cllre_pkg::ID_W),
    .DEPTH(NODE_COUNT)
  ) u_prev_tab (
    .clk  (clk),
    .we   (req.prev_we),
    .waddr(ADDR_W'(req.prev_waddr)),
    .wdata(req.prev_wdata),
    .raddr(ADDR_W'(req.raddr)),
    .rdata(prev_rdata)
  );

endmodule
`default_nettype wire

/* hw/rtl/cllre_checker.sv */
// Port-level checker for the circular linked ring editor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cllre_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic [cllre_pkg::IN_TDATA_W-1:0]  s_tdata,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [cllre_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic s_acc;
  logic [cllre_pkg::ACT_W-1:0] s_act;

  assign s_acc = s_tvalid && s_tready;
  assign s_act = s_tdata[cllre_pkg::ACT_W-1:0];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("Result dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("Result changed while stalled.");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_act <= cllre_pkg::ACT_REM_BEFORE) |=> !s_tready)
    else $error("Ready while a request is in progress.");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_act == cllre_pkg::ACT_LOAD) |=> !$rose(m_tvalid))
    else $error("Load request produced a result.");

endmodule

bind circular_linked_ring_editor_core cllre_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for the circular linked ring editor core with a ring-tracking scoreboard.
`timescale 1ns / 1ps
module tb;
  import cllre_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_HI  = 3'd7;

  class ring_scoreboard;
    node_id_t next_tab[NODE_COUNT];
    node_id_t prev_tab[NODE_COUNT];
    bit       next_set[NODE_COUNT];
    bit       prev_set[NODE_COUNT];
    node_id_t linked_ids[$];
    node_id_t head;
    node_id_t tail;
    bit       started;
    node_id_t neighbour_q[$];
    int       failures;

    function void link_next(node_id_t id, node_id_t v);
      if (!next_set[id] && !prev_set[id]) linked_ids.push_back(id);
      next_tab[id] = v;
      next_set[id] = 1'b1;
    endfunction

    function void link_prev(node_id_t id, node_id_t v);
      if (!next_set[id] && !prev_set[id]) linked_ids.push_back(id);
      prev_tab[id] = v;
      prev_set[id] = 1'b1;
    endfunction

    // Only links that have been written may be read by the block.
    function bit can_issue(logic [ACT_W-1:0] act, node_id_t a);
      case (act)
        ACT_INS_AFTER:  return next_set[a];
        ACT_INS_BEFORE: return prev_set[a];
        ACT_REM_AFTER:  return next_set[a] && next_set[next_tab[a]];
        ACT_REM_BEFORE: return prev_set[a] && prev_set[prev_tab[a]];
        default:        return 1'b1;
      endcase
    endfunction

    function void note_request(logic [ACT_W-1:0] act, node_id_t a, node_id_t b);
      node_id_t c;
      node_id_t d;
      case (act)
        ACT_LOAD: begin
          if (!started) begin
            link_next(a, a);
            link_prev(a, a);
            head = a;
            started = 1'b1;
          end else begin
            link_next(tail, a);
            link_prev(a, tail);
            link_next(a, head);
            link_prev(head, a);
          end
          tail = a;
        end
        ACT_INS_AFTER: begin
          c = next_tab[a];
          link_next(b, c);
          link_prev(b, a);
          link_next(a, b);
          link_prev(c, b);
          neighbour_q.push_back(c);
        end
        ACT_INS_BEFORE: begin
          c = prev_tab[a];
          link_prev(b, c);
          link_next(b, a);
          link_prev(a, b);
          link_next(c, b);
          neighbour_q.push_back(c);
        end
        ACT_REM_AFTER: begin
          c = next_tab[a];
          d = next_tab[c];
          link_next(a, d);
          link_prev(d, a);
          neighbour_q.push_back(c);
        end
        ACT_REM_BEFORE: begin
          c = prev_tab[a];
          d = prev_tab[c];
          link_prev(a, d);
          link_next(d, a);
          neighbour_q.push_back(c);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(node_id_t got);
      node_id_t want;
      if (neighbour_q.size() == 0) begin
        $error("neighbour: expected none, actual %0d", got);
        failures++;
      end else begin
        want = neighbour_q.pop_front();
        if (want !== got) begin
          $error("neighbour: expected %0d, actual %0d", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  ring_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  circular_linked_ring_editor_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  task automatic send_request(input logic [ACT_W-1:0] act, input node_id_t a,
                              input node_id_t b);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[ACT_W-1:0] = act;
    word[ACT_W +: ID_W] = a;
    word[ACT_W+ID_W +: ID_W] = b;
    s_tdata <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_request(act, a, b);
  endtask

  task automatic sender_pause();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic node_id_t any_node();
    return node_id_t'($urandom_range(0, NODE_COUNT - 1));
  endfunction

  function automatic node_id_t fresh_node();
    node_id_t n;
    n = any_node();
    for (int i = 0; i < 32 && (sb.next_set[n] || sb.prev_set[n]); i++) n = any_node();
    return n;
  endfunction

  task automatic send_random();
    int pick;
    logic [ACT_W-1:0] act;
    node_id_t a;
    node_id_t b;
    bit found;
    pick = $urandom_range(0, 99);
    a = any_node();
    b = any_node();
    if (!sb.started || pick < 25) begin
      act = ACT_LOAD;
      if ($urandom_range(0, 9) != 0) a = fresh_node();
    end else if (pick < 32) begin
      act = ACT_W'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    end else begin
      if (pick < 57) begin
        act = $urandom_range(0, 1) ? ACT_INS_AFTER : ACT_INS_BEFORE;
        if ($urandom_range(0, 6) != 0) b = fresh_node();
      end else begin
        act = $urandom_range(0, 1) ? ACT_REM_AFTER : ACT_REM_BEFORE;
      end
      found = 1'b0;
      for (int i = 0; i < 16 && !found; i++) begin
        a = sb.linked_ids[$urandom_range(0, sb.linked_ids.size() - 1)];
        found = sb.can_issue(act, a);
      end
      if (!found) begin
        act = ACT_LOAD;
        a = fresh_node();
      end
    end
    send_request(act, a, b);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_result(m_tdata[ID_W-1:0]);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: first load, field extremes, unused codes, degenerate splices.
    send_request(ACT_LOAD, 10'd0, 10'd1023);       sender_pause();
    send_request(ACT_LOAD, 10'd1023, 10'd0);       sender_pause();
    send_request(ACT_LOAD, 10'd5, 10'd682);        sender_pause();
    send_request(ACT_RSVD_LO, 10'd1023, 10'd1023); sender_pause();
    send_request(ACT_RSVD_MID, 10'd0, 10'd0);      sender_pause();
    send_request(ACT_RSVD_HI, 10'd682, 10'd341);   sender_pause();
    send_request(ACT_INS_AFTER, 10'd0, 10'd682);   sender_pause();
    send_request(ACT_INS_BEFORE, 10'd1023, 10'd341); sender_pause();
    send_request(ACT_INS_AFTER, 10'd1023, 10'd0);  sender_pause();
    send_request(ACT_REM_AFTER, 10'd0, 10'd1023);  sender_pause();
    send_request(ACT_REM_BEFORE, 10'd1023, 10'd0); sender_pause();
    send_request(ACT_LOAD, 10'd5, 10'd5);          sender_pause();
    send_request(ACT_INS_AFTER, 10'd5, 10'd5);     sender_pause();
    send_request(ACT_INS_BEFORE, 10'd682, 10'd0);  sender_pause();
    send_request(ACT_REM_AFTER, 10'd5, 10'd341);   sender_pause();
    send_request(ACT_REM_BEFORE, 10'd5, 10'd682);  sender_pause();
    send_request(ACT_REM_AFTER, 10'd1023, 10'd0);  sender_pause();
    send_request(ACT_INS_BEFORE, 10'd0, 10'd1023); sender_pause();

    for (int i = 0; i < 150; i++) begin
      send_random();
      sender_pause();
    end

    // The sink holds off while requests keep coming, so the core backs up.
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_random();

    for (int i = 0; i < 150; i++) begin
      send_random();
      sender_pause();
    end

    quiet = 1'b1;
    for (int i = 0; i < 80; i++) send_random();
    s_tvalid <= 1'b0;

    while (sb.neighbour_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
